/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define NPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define NPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/npa_pkg.sv */
// ----------------------------------------------------------------------------
// npa_pkg
// Types, constants and helpers for the next-fit page allocator.
// ----------------------------------------------------------------------------
package npa_pkg;

  localparam int TABLE_PAGES  = 1024;
  localparam int USER_LO_PAGE = 256;
  localparam int USER_HI_PAGE = 960;

  localparam int PAGE_W = 10;
  localparam int CFG_W  = 11;

  // upper end of the scan, clipped to the table
  localparam int HI_EFF   = (USER_HI_PAGE > TABLE_PAGES) ? TABLE_PAGES : USER_HI_PAGE;
  localparam bit RANGE_OK = (USER_LO_PAGE < HI_EFF);

  // bitmap row organisation
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = TABLE_PAGES / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int LO_W      = USER_LO_PAGE / WORD_W;
  localparam int HI_W      = (HI_EFF - 1) / WORD_W;
  localparam int NSTEPS    = HI_W - LO_W + 1;
  localparam int STEP_W    = $clog2(NUM_WORDS + 1);

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_SET,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] page_index;
    logic              usable_flag;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    logic              granted;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] page;
    logic              flag;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } cq_status_t;

  // pages of row w that lie in the user range
  function automatic logic [WORD_W-1:0] range_mask(logic [WADDR_W-1:0] w);
    logic [WORD_W-1:0] m;
    int                p;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      p    = int'(w) * WORD_W + b;
      m[b] = (p >= USER_LO_PAGE) && (p < HI_EFF);
    end
    return m;
  endfunction

endpackage

/* src/npa_front.sv */
// ----------------------------------------------------------------------------
// npa_front
// Accepts request items and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module npa_front import npa_pkg::*; (
  input  logic       push,
  output logic       full,
  input  req_t       req_i,
  input  logic       cfg_zero_i,
  input  cq_status_t cq_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic in_table;

  assign in_table   = int'(req_i.page_index) < TABLE_PAGES;
  assign full       = cq_i.full;
  assign cmd_push_o = push && !cq_i.full;

  always_comb begin
    cmd_o.page = req_i.page_index;
    cmd_o.flag = req_i.usable_flag;
    unique case (req_i.req_type)
      REQ_ALLOC: begin
        cmd_o.op = (cfg_zero_i || !RANGE_OK) ? OP_NOP : OP_ALLOC;
      end
      REQ_FREE: begin
        cmd_o.op = in_table ? OP_FREE : OP_NOP;
      end
      REQ_SET: begin
        cmd_o.op = in_table ? OP_SET : OP_NOP;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

/* src/npa_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// npa_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module npa_cmd_fifo import npa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmd_t       cmd_o,
  output cq_status_t status_o
);

  cmd_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign status_o.valid = (cnt_q != 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign cmd_o          = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* src/npa_back.sv */
// ----------------------------------------------------------------------------
// npa_back
// Executes commands against the page bitmaps and holds the result item.
// ----------------------------------------------------------------------------
module npa_back import npa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  cq_status_t cq_i,
  output logic       cmd_pop_o,
  input  logic       pop,
  output logic       empty,
  output rsp_t       rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESP
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [WADDR_W-1:0]  word_q;
  logic [STEP_W-1:0]   step_q;
  logic [PAGE_W-1:0]   rover_q;
  rsp_t                pend_q;
  rsp_t                rsp_q;
  logic                rsp_vld_q;

  // bitmap rows: {allocated, usable}
  logic [2*WORD_W-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  logic [2*WORD_W-1:0] rd_data_q;
  logic                rd_vld_q;

  logic                mem_re, mem_we;
  logic [WADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [2*WORD_W-1:0] mem_wdata;

  logic [PAGE_W-1:0]   rover_fix;
  logic [WORD_W-1:0]   use_w, alc_w, use_n, alc_n;
  logic [WORD_W-1:0]   step_mask, cand;
  logic [BIT_W-1:0]    rb, hit_bit, cmd_bit;
  logic                hit, last_step, slot_free;
  logic [WADDR_W-1:0]  next_word;

  assign rover_fix = (int'(rover_q) >= USER_LO_PAGE && int'(rover_q) < HI_EFF) ?
                     rover_q : PAGE_W'(USER_LO_PAGE);
  assign use_w     = rd_vld_q ? rd_data_q[WORD_W-1:0] : '0;
  assign alc_w     = rd_vld_q ? rd_data_q[2*WORD_W-1:WORD_W] : '0;
  assign rb        = rover_q[BIT_W-1:0];
  assign cmd_bit   = cmd_q.page[BIT_W-1:0];
  assign last_step = (step_q == STEP_W'(NSTEPS));
  assign next_word = (word_q == WADDR_W'(HI_W)) ? WADDR_W'(LO_W) : word_q + 1'b1;
  assign slot_free = !rsp_vld_q || pop;
  assign cmd_pop_o = (state_q == ST_IDLE) && cq_i.valid;
  assign empty     = !rsp_vld_q;
  assign rsp_o     = rsp_q;

  // first lap covers bits at or above the rover, the closing lap the rest
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      if (step_q == '0) begin
        step_mask[b] = (b >= int'(rb));
      end else if (last_step) begin
        step_mask[b] = (b < int'(rb));
      end else begin
        step_mask[b] = 1'b1;
      end
    end
  end

  assign cand = use_w & ~alc_w & range_mask(word_q) & step_mask;
  assign hit  = |cand;

  always_comb begin
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    use_n = use_w;
    alc_n = alc_w;
    unique case (cmd_q.op)
      OP_ALLOC: alc_n[hit_bit] = 1'b1;
      OP_FREE:  alc_n[cmd_bit] = 1'b0;
      OP_SET:   use_n[cmd_bit] = cmd_q.flag;
      default: ;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cmd_i.page[PAGE_W-1:BIT_W];
    mem_we    = 1'b0;
    mem_waddr = cmd_q.page[PAGE_W-1:BIT_W];
    mem_wdata = {alc_n, use_n};
    unique case (state_q)
      ST_IDLE: begin
        if (cq_i.valid) begin
          mem_re = (cmd_i.op != OP_NOP);
          if (cmd_i.op == OP_ALLOC) begin
            mem_raddr = rover_fix[PAGE_W-1:BIT_W];
          end
        end
      end
      ST_EVAL: begin
        if (cmd_q.op == OP_ALLOC) begin
          mem_waddr = word_q;
          mem_we    = hit;
          mem_re    = !hit && !last_step;
          mem_raddr = next_word;
        end else begin
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= '0;
      word_q    <= '0;
      step_q    <= '0;
      rover_q   <= PAGE_W'(USER_LO_PAGE);
      pend_q    <= '0;
      rsp_q     <= '0;
      rsp_vld_q <= 1'b0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= row_vld_q[mem_raddr];
      end
      if (pop && rsp_vld_q && state_q != ST_RESP) begin
        rsp_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cq_i.valid) begin
            cmd_q  <= cmd_i;
            pend_q <= '0;
            step_q <= '0;
            if (cmd_i.op == OP_ALLOC) begin
              rover_q <= rover_fix;
              word_q  <= rover_fix[PAGE_W-1:BIT_W];
            end
            state_q <= (cmd_i.op == OP_NOP) ? ST_RESP : ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (cmd_q.op != OP_ALLOC) begin
            state_q <= ST_RESP;
          end else if (hit) begin
            rover_q <= {word_q, hit_bit};
            pend_q  <= '{granted_page: {word_q, hit_bit}, granted: 1'b1};
            state_q <= ST_RESP;
          end else if (last_step) begin
            state_q <= ST_RESP;
          end else begin
            step_q <= step_q + 1'b1;
            word_q <= next_word;
          end
        end
        ST_RESP: begin
          if (slot_free) begin
            rsp_q     <= pend_q;
            rsp_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            rsp_vld_q <= rsp_vld_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/next_fit_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// next_fit_page_allocator_unit
// Next-fit page allocator over a usable/allocated bitmap pair.
//
// Requests are pushed into a two-entry command queue and executed one at a
// time against a 32-row memory holding 32 pages per row; a row-valid flop per
// row makes both bitmaps read as zero after reset, so no clearing pass is
// needed. Free and set requests pass through the idle, evaluate and respond
// states, an unknown request or an allocate while pages_present is zero skips
// evaluate, and an allocate stays in evaluate for k rows (one row per cycle
// through the memory read port), where k runs from 1 up to the row count of
// the user range plus one: 23 at the default range. The result item waits in
// an output register while the next item is accepted and started.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_fit_page_allocator_unit import npa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  req_t             req_i,
  output logic             empty,
  input  logic             pop,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] pages_present_q;
  logic             cmd_push, cmd_pop;
  cmd_t             front_cmd, queue_cmd;
  cq_status_t       cq_status;
  logic             rsp_fail, rsp_grant, grant_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_present_q <= '0;
    end else if (cfg_we_i) begin
      pages_present_q <= cfg_wdata_i;
    end
  end

  npa_front u_front (
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .cfg_zero_i (pages_present_q == '0),
    .cq_i       (cq_status),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  npa_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .cmd_i    (front_cmd),
    .pop_i    (cmd_pop),
    .cmd_o    (queue_cmd),
    .status_o (cq_status)
  );

  npa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (queue_cmd),
    .cq_i      (cq_status),
    .cmd_pop_o (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .rsp_o     (rsp_o)
  );

  assign rsp_fail       = !empty && !rsp_o.granted;
  assign rsp_grant      = !empty && rsp_o.granted;
  assign grant_in_range = int'(rsp_o.granted_page) >= USER_LO_PAGE &&
                          int'(rsp_o.granted_page) < HI_EFF;

  `NPA_ASSERT_IMP(a_fail_page_zero, rsp_fail, rsp_o.granted_page == '0, "failed item has a page")
  `NPA_ASSERT_IMP(a_grant_in_range, rsp_grant, grant_in_range, "granted page outside user range")
  `NPA_ASSERT_IMP(a_full_has_cmd, cq_status.full, cq_status.valid, "command queue full but empty")
  `NPA_ASSERT_NXT(a_pop_only_valid, cmd_pop, !cq_status.full, "queue still full after a pop")

endmodule
